>>> src/sorted_snake_matrix_fill_core_defines.svh
// Assertion macros shared by the sorted snake matrix modules.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef SORTED_SNAKE_MATRIX_FILL_CORE_DEFINES_SVH
`define SORTED_SNAKE_MATRIX_FILL_CORE_DEFINES_SVH

// Check a same-cycle implication, quiet while reset is asserted.
`define SSMF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the following cycle, quiet while reset is asserted.
`define SSMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ssmf_pkg.sv
// Shared constants, types and helpers of the sorted snake matrix block.
// No dependencies; the sorter, the top level and the bench import this package.
`timescale 1ns / 1ps

package ssmf_pkg;

    // Sizing
    localparam int MAX_DIM     = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);

    // Port field widths
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_SORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd3;

    // Register indexes and reset value
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;
    localparam logic [CFG_W-1:0]     DIM_RESET     = 5'd1;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;

    // Read and write requests issued to the element memory
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        elem_t             wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // Sort launch from the controller
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } sort_cmd_t;

    // Map a register value onto 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end
        else if (int'(d) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end
        else begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

    // Wrap an input value to the stored width
    function automatic elem_t to_elem(input logic signed [VALUE_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

    // Sign-extend or cut a stored value to the port width
    function automatic logic signed [VALUE_W-1:0] from_elem(input elem_t e);
        return VALUE_W'(e);
    endfunction

endpackage

>>> src/ssmf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ssmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register the read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/ssmf_sorter.sv
// In-memory bubble sort sequencer: streams each pass through the element RAM.
// Depends on ssmf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_snake_matrix_fill_core_defines.svh"

module ssmf_sorter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssmf_pkg::sort_cmd_t  cmd,
    input  ssmf_pkg::elem_t      rd_data,
    output ssmf_pkg::ram_req_t   ram_req,
    output logic                 busy
);
    import ssmf_pkg::*;

    typedef enum logic [2:0] {
        SRT_IDLE = 3'b001,
        SRT_RUN  = 3'b010,
        SRT_TAIL = 3'b100
    } srt_state_t;

    srt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] pass_len_reg, pass_len_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] rd_at_reg, rd_at_next;
    logic             rd_vld_reg, rd_vld_next;
    elem_t            carry_reg, carry_next;
    logic [CNT_W-1:0] last_idx;

    assign last_idx = pass_len_reg - CNT_W'(1);
    assign busy     = (state_reg != SRT_IDLE);

    // Carry the running maximum along the pass, drop the smaller value behind it
    always_comb
    begin
        state_next    = state_reg;
        pass_len_next = pass_len_reg;
        rd_idx_next   = rd_idx_reg;
        rd_at_next    = rd_at_reg;
        rd_vld_next   = 1'b0;
        carry_next    = carry_reg;
        ram_req       = '0;
        unique case (state_reg)
            SRT_IDLE:
            begin
                if (cmd.start)
                begin
                    pass_len_next = cmd.count;
                    rd_idx_next   = '0;
                    state_next    = SRT_RUN;
                end
            end
            SRT_RUN:
            begin
                if (rd_idx_reg < pass_len_reg)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next     = rd_idx_reg + CNT_W'(1);
                    rd_vld_next     = 1'b1;
                    rd_at_next      = rd_idx_reg;
                end
                if (rd_vld_reg)
                begin
                    if (rd_at_reg == '0)
                    begin
                        carry_next = rd_data;
                    end
                    else
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = ADDR_W'(rd_at_reg - CNT_W'(1));
                        if (carry_reg > rd_data)
                        begin
                            ram_req.wr_data = rd_data;
                        end
                        else
                        begin
                            ram_req.wr_data = carry_reg;
                            carry_next      = rd_data;
                        end
                    end
                    if (rd_at_reg == last_idx)
                    begin
                        state_next = SRT_TAIL;
                    end
                end
            end
            SRT_TAIL:
            begin
                // Park the pass maximum at the end and shorten the next pass
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = last_idx[ADDR_W-1:0];
                ram_req.wr_data = carry_reg;
                pass_len_next   = last_idx;
                rd_idx_next     = '0;
                state_next      = (last_idx < CNT_W'(2)) ? SRT_IDLE : SRT_RUN;
            end
            default:
            begin
                state_next = SRT_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SRT_IDLE;
            pass_len_reg <= '0;
            rd_idx_reg   <= '0;
            rd_at_reg    <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_len_reg <= pass_len_next;
            rd_idx_reg   <= rd_idx_next;
            rd_at_reg    <= rd_at_next;
            rd_vld_reg   <= rd_vld_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    `SSMF_ASSERT_IMPL(a_wr_inside_pass, ram_req.wr_en, ram_req.wr_addr < pass_len_reg,
        "sorter writes beyond the current pass")
    `SSMF_ASSERT_IMPL(a_no_rw_collision, ram_req.wr_en && ram_req.rd_en,
        ram_req.wr_addr != ram_req.rd_addr, "sorter reads and writes one entry at once")
    `SSMF_ASSERT_IMPL(a_start_when_idle, cmd.start, state_reg == SRT_IDLE,
        "sort launched while a sort is running")

endmodule

>>> src/sorted_snake_matrix_fill_core.sv
// Top level of the sorted snake matrix: command decode, load and read paths,
// result staging. Depends on ssmf_pkg, ssmf_ram, ssmf_sorter and the macro header.
`timescale 1ns / 1ps
`include "sorted_snake_matrix_fill_core_defines.svh"

// Usage:
// - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets row_count (index 0)
//   and col_count (index 1); cfg_ready is always high. Write only while idle.
// - in channel beats carry a command: load a value, read a row/column of the
//   column-snake or row-snake layout, or clear. Loads and reads give one result
//   beat on the out channel (value_out, status); clears give none.
// - Results pass through the result stage and then the output register to out.
// - Throughput: one beat per cycle for loads, reads and clears while in_ready is
//   high; a load or a read makes at most one element RAM access, a clear none.
// - The load that fills rows*cols entries starts an in-RAM bubble sort (not for a
//   1x1 matrix); in_ready stays low until it ends. The sorter makes at most one
//   RAM read and one RAM write per cycle.
// - Reset empties the matrix and sets both dimensions to 1; RAM content is not
//   cleared, since no entry is read before it is written.
// - A stalled out channel holds its beat; one more input beat is taken into the
//   result stage, after which in_ready drops until out_ready returns.
module sorted_snake_matrix_fill_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssmf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ssmf_pkg::CMD_W-1:0]           command,
    input  logic signed [ssmf_pkg::VALUE_W-1:0]  value,
    input  logic                                 layout,
    input  logic [ssmf_pkg::POS_W-1:0]           row,
    input  logic [ssmf_pkg::POS_W-1:0]           col,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ssmf_pkg::VALUE_W-1:0]  value_out,
    output logic [ssmf_pkg::STATUS_W-1:0]        status
);
    import ssmf_pkg::*;

    localparam int IDX_W = POS_W + DIM_W + 1;

    // Configuration and matrix state
    logic [CFG_W-1:0]    row_count_reg, col_count_reg;
    logic [CNT_W-1:0]    loaded_count_reg, loaded_count_next;
    logic                sorted_flag_reg, sorted_flag_next;

    // Result stage and output register
    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_from_ram_reg, res_from_ram_next;
    logic                res_move;
    logic                out_valid_reg;
    logic signed [VALUE_W-1:0] value_out_reg;
    logic [STATUS_W-1:0] status_reg;

    // Decode helpers
    logic                accept;
    logic [DIM_W-1:0]    rows, cols;
    logic [2*DIM_W-1:0]  cap_full;
    logic [CNT_W-1:0]    cap;
    logic [CNT_W-1:0]    count_inc;
    logic [IDX_W-1:0]    row_x, col_x, rows_x, cols_x, idx_full;
    logic                pos_in_range;

    // Memory and sorter
    ram_req_t            ram_req, sort_req, host_req;
    elem_t               ram_rd_data;
    sort_cmd_t           sort_cmd;
    logic                sort_busy;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign res_move  = res_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !sort_busy && (!res_valid_reg || res_move);

    // Effective dimensions and capacity
    assign rows      = clamp_dim(row_count_reg);
    assign cols      = clamp_dim(col_count_reg);
    assign cap_full  = rows * cols;
    assign cap       = CNT_W'(cap_full);
    assign count_inc = loaded_count_reg + CNT_W'(1);

    // Snake index of the requested position
    assign row_x  = IDX_W'(row);
    assign col_x  = IDX_W'(col);
    assign rows_x = IDX_W'(rows);
    assign cols_x = IDX_W'(cols);

    always_comb
    begin
        if (layout == 1'b0)
        begin
            idx_full = col_x * rows_x + (col[0] ? (rows_x - IDX_W'(1) - row_x) : row_x);
        end
        else
        begin
            idx_full = row_x * cols_x + (row[0] ? (cols_x - IDX_W'(1) - col_x) : col_x);
        end
    end

    assign pos_in_range = (row_x < rows_x) && (col_x < cols_x)
                          && (idx_full < loaded_count_reg);

    // Decode accepted beats into memory requests and staged results
    always_comb
    begin
        loaded_count_next = loaded_count_reg;
        sorted_flag_next  = sorted_flag_reg;
        res_valid_next    = res_move ? 1'b0 : res_valid_reg;
        res_status_next   = res_status_reg;
        res_from_ram_next = res_from_ram_reg;
        host_req          = '0;
        sort_cmd          = '0;
        if (accept)
        begin
            unique case (command)
                CMD_LOAD:
                begin
                    res_valid_next    = 1'b1;
                    res_from_ram_next = 1'b0;
                    if (sorted_flag_reg || (loaded_count_reg >= cap))
                    begin
                        res_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        res_status_next   = ST_OK;
                        host_req.wr_en    = 1'b1;
                        host_req.wr_addr  = loaded_count_reg[ADDR_W-1:0];
                        host_req.wr_data  = to_elem(value);
                        loaded_count_next = count_inc;
                        if (count_inc == cap)
                        begin
                            sorted_flag_next = 1'b1;
                            sort_cmd.start   = (cap != CNT_W'(1));
                            sort_cmd.count   = cap;
                        end
                    end
                end
                CMD_READ:
                begin
                    res_valid_next    = 1'b1;
                    res_from_ram_next = 1'b0;
                    if (!sorted_flag_reg)
                    begin
                        res_status_next = ST_NOT_SORTED;
                    end
                    else if (!pos_in_range)
                    begin
                        res_status_next = ST_RANGE;
                    end
                    else
                    begin
                        res_status_next   = ST_OK;
                        res_from_ram_next = 1'b1;
                        host_req.rd_en    = 1'b1;
                        host_req.rd_addr  = idx_full[ADDR_W-1:0];
                    end
                end
                CMD_CLEAR:
                begin
                    loaded_count_next = '0;
                    sorted_flag_next  = 1'b0;
                end
                default:
                begin
                    loaded_count_next = loaded_count_reg;
                end
            endcase
        end
    end

    // Give the sorter the memory while it runs
    assign ram_req = sort_busy ? sort_req : host_req;

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_RESET;
            col_count_reg    <= DIM_RESET;
            loaded_count_reg <= '0;
            sorted_flag_reg  <= 1'b0;
            res_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT: row_count_reg <= cfg_data;
                    REG_COL_COUNT: col_count_reg <= cfg_data;
                    default:       row_count_reg <= row_count_reg;
                endcase
            end
            loaded_count_reg <= loaded_count_next;
            sorted_flag_reg  <= sorted_flag_next;
            res_valid_reg    <= res_valid_next;
            if (res_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Advance result payload into the output register
    always_ff @(posedge clk)
    begin
        res_status_reg   <= res_status_next;
        res_from_ram_reg <= res_from_ram_next;
        if (res_move)
        begin
            value_out_reg <= res_from_ram_reg ? from_elem(ram_rd_data) : '0;
            status_reg    <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;

    ssmf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    ssmf_sorter u_sorter (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (sort_cmd),
        .rd_data (ram_rd_data),
        .ram_req (sort_req),
        .busy    (sort_busy)
    );

    `SSMF_ASSERT_NEXT(a_read_unsorted, accept && command == CMD_READ && !sorted_flag_reg,
        res_valid_reg && res_status_reg == ST_NOT_SORTED, "early read not flagged")
    `SSMF_ASSERT_IMPL(a_ram_result_ok, res_valid_reg && res_from_ram_reg,
        res_status_reg == ST_OK, "memory data staged with an error status")
    `SSMF_ASSERT_IMPL(a_sort_done_sorted, $fell(sort_busy), sorted_flag_reg,
        "sort ended without the sorted flag")
    `SSMF_ASSERT_NEXT(a_load_counts,
        accept && command == CMD_LOAD && !sorted_flag_reg && loaded_count_reg < cap,
        loaded_count_reg == $past(loaded_count_reg) + CNT_W'(1), "load count not advanced")

endmodule

>>> tb/tb.sv
// Self-checking bench for sorted_snake_matrix_fill_core: loads, sorts and snake-order reads.
// Needs ssmf_pkg and the core RTL; a built-in predictor supplies the expected result beats.
`timescale 1ns / 1ps

module tb;
    import ssmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_PAUSE    = 10;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_BEATS    = 25;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        logic                      layout;
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
    } matrix_cmd_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } matrix_result_t;

    // DUT connections
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [CMD_W-1:0]          command = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      layout = 1'b0;
    logic [POS_W-1:0]          row = '0;
    logic [POS_W-1:0]          col = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] value_out;
    logic [STATUS_W-1:0]       status;

    // Stimulus and expectation queues
    matrix_cmd_t    cmd_backlog[$];
    matrix_result_t result_due[$];

    // Predictor state
    elem_t           model_store [STORE_DEPTH];
    int              model_count = 0;
    bit              model_sorted = 1'b0;
    logic [CFG_W-1:0] model_rows_reg = DIM_RESET;
    logic [CFG_W-1:0] model_cols_reg = DIM_RESET;

    // Run control and bookkeeping
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit stall_req = 1'b0;
    int stall_left = 0;
    bit in_beat_taken = 1'b0;
    int idle_cycles = 0;
    int fail_count = 0;
    int results_checked = 0;
    int beats_taken = 0;
    int reg_writes = 0;
    int sorts_done = 0;
    int stim_beats = 0;

    sorted_snake_matrix_fill_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .layout    (layout),
        .row       (row),
        .col       (col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value_out (value_out),
        .status    (status)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Map a register value onto the dimension actually used
    function automatic int dim_in_use(input logic [CFG_W-1:0] d);
        int r;
        r = int'(d);
        if (r < 1)
        begin
            r = 1;
        end
        else if (r > MAX_DIM)
        begin
            r = MAX_DIM;
        end
        return r;
    endfunction

    // Ascending insertion sort of the first n stored values
    task automatic sort_model(input int n);
        elem_t held;
        int j;
        for (int i = 1; i < n; i++)
        begin
            held = model_store[i];
            j = i;
            while (j > 0 && model_store[j-1] > held)
            begin
                model_store[j] = model_store[j-1];
                j--;
            end
            model_store[j] = held;
        end
    endtask

    // Advance the matrix state by one command and queue the result it owes
    task automatic apply_command(input matrix_cmd_t c);
        int rows_in_use;
        int cols_in_use;
        int cap;
        int idx;
        matrix_result_t res;
        rows_in_use = dim_in_use(model_rows_reg);
        cols_in_use = dim_in_use(model_cols_reg);
        cap = rows_in_use * cols_in_use;
        res.value = '0;
        res.status = ST_OK;
        case (c.cmd)
            CMD_CLEAR:
            begin
                model_count = 0;
                model_sorted = 1'b0;
            end
            CMD_LOAD:
            begin
                if (model_sorted || model_count >= cap)
                begin
                    res.status = ST_OVERFLOW;
                end
                else
                begin
                    model_store[model_count] = c.value;
                    model_count++;
                    if (model_count == cap)
                    begin
                        sort_model(model_count);
                        model_sorted = 1'b1;
                        sorts_done++;
                    end
                end
                result_due.push_back(res);
            end
            CMD_READ:
            begin
                if (!model_sorted)
                begin
                    res.status = ST_NOT_SORTED;
                end
                else if (c.row >= rows_in_use || c.col >= cols_in_use)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    if (c.layout == 1'b0)
                    begin
                        idx = c.col * rows_in_use
                            + (c.col[0] ? rows_in_use - 1 - c.row : c.row);
                    end
                    else
                    begin
                        idx = c.row * cols_in_use
                            + (c.row[0] ? cols_in_use - 1 - c.col : c.col);
                    end
                    if (idx >= model_count)
                    begin
                        res.status = ST_RANGE;
                    end
                    else
                    begin
                        res.value = model_store[idx];
                    end
                end
                result_due.push_back(res);
            end
            default:
            begin
                // unknown command: dropped without a result
            end
        endcase
    endtask

    // Input driver: hold an offered beat until taken, else offer the next or idle
    always @(negedge clk)
    begin : drive_in
        matrix_cmd_t beat;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_beat_taken)
        begin
            // hold the beat
        end
        else if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            beat = cmd_backlog.pop_front();
            in_valid <= 1'b1;
            command  <= beat.cmd;
            value    <= beat.value;
            layout   <= beat.layout;
            row      <= beat.row;
            col      <= beat.col;
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Output ready: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (stall_req)
        begin
            stall_left = LONG_HOLD;
            stall_req = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check result beats, then track register writes and input beats
    always @(posedge clk)
    begin : watch_ports
        matrix_result_t want;
        matrix_cmd_t    seen;
        in_beat_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (result_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, value_out %0d status %0d",
                             $time, value_out, status);
                    fail_count++;
                end
                else
                begin
                    want = result_due.pop_front();
                    if (value_out !== want.value)
                    begin
                        $display("%0t: value_out mismatch, expected %0d actual %0d",
                                 $time, want.value, value_out);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, status);
                        fail_count++;
                    end
                    results_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROW_COUNT)
                begin
                    model_rows_reg = cfg_data;
                end
                else
                begin
                    model_cols_reg = cfg_data;
                end
                reg_writes++;
            end
            if (in_valid && in_ready)
            begin
                seen.cmd    = command;
                seen.value  = value;
                seen.layout = layout;
                seen.row    = row;
                seen.col    = col;
                apply_command(seen);
                beats_taken++;
            end
        end
    end

    // Watchdog: end the run when no channel moves a beat for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, result_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Spread values over extremes, near-duplicates and the full range
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = '0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2:
            begin
                v = $signed($urandom_range(6)) - 32'sd3;
            end
            default:
            begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    // Random layout and position fields
    function automatic logic pick_layout();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(input int hi);
        return POS_W'($urandom_range(hi));
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] v,
                             input logic lay, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] c);
        matrix_cmd_t item;
        item.cmd = cmd;
        item.value = v;
        item.layout = lay;
        item.row = r;
        item.col = c;
        cmd_backlog.push_back(item);
        if (cmd != CMD_UNUSED)
        begin
            stim_beats++;
        end
    endtask

    // Loads carry random read fields, reads a random value, so every bit toggles
    task automatic queue_load(input logic signed [VALUE_W-1:0] v);
        queue_cmd(CMD_LOAD, v, pick_layout(), pick_pos(15), pick_pos(15));
    endtask

    task automatic queue_read(input logic lay, input logic [POS_W-1:0] r,
                              input logic [POS_W-1:0] c);
        queue_cmd(CMD_READ, $urandom, lay, r, c);
    endtask

    task automatic queue_clear();
        queue_cmd(CMD_CLEAR, $urandom, pick_layout(), pick_pos(15), pick_pos(15));
    endtask

    task automatic queue_unused();
        queue_cmd(CMD_UNUSED, $urandom, pick_layout(), pick_pos(15), pick_pos(15));
    endtask

    // Wait until every beat is sent and answered and no sort is running
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end while (cmd_backlog.size() != 0 || in_valid || result_due.size() != 0 || !in_ready);
        repeat (DRAIN_PAUSE) @(posedge clk);
        do
        begin
            @(posedge clk);
            #1;
        end while (!in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One matrix life: size it, fill it, read it back, with noise and broken variants
    task automatic random_round(input logic [CFG_W-1:0] rows_set,
                                input logic [CFG_W-1:0] cols_set, input bit hold_output);
        int rows_in_use;
        int cols_in_use;
        int cap;
        int kept;
        rows_in_use = dim_in_use(rows_set);
        cols_in_use = dim_in_use(cols_set);
        cap = rows_in_use * cols_in_use;
        wait_idle();
        write_reg(REG_ROW_COUNT, rows_set);
        write_reg(REG_COL_COUNT, cols_set);
        if (hold_output)
        begin
            stall_req = 1'b1;
        end
        queue_clear();
        if (cap > 2 && $urandom_range(7) == 0)
        begin
            // stop short, then shrink the matrix under the values already loaded
            kept = $urandom_range(cap - 1, 2);
            repeat (kept) queue_load(pick_value());
            wait_idle();
            write_reg(REG_ROW_COUNT, 5'd1);
            write_reg(REG_COL_COUNT, CFG_W'($urandom_range(kept < MAX_DIM ? kept : MAX_DIM, 1)));
            queue_load(pick_value());
            queue_read(pick_layout(), pick_pos(15), pick_pos(15));
            queue_load(pick_value());
        end
        else
        begin
            for (int i = 0; i < cap; i++)
            begin
                if ($urandom_range(15) == 0)
                begin
                    queue_read(pick_layout(), pick_pos(15), pick_pos(15));
                end
                if ($urandom_range(31) == 0)
                begin
                    queue_unused();
                end
                queue_load(pick_value());
            end
            repeat ($urandom_range(12, 4))
            begin
                case ($urandom_range(9))
                    0: queue_load(pick_value());
                    1: queue_read(pick_layout(), pick_pos(15), pick_pos(15));
                    default: queue_read(pick_layout(), pick_pos(rows_in_use - 1),
                                        pick_pos(cols_in_use - 1));
                endcase
            end
            if ($urandom_range(4) == 0)
            begin
                // grow after sorting: positions past the loaded values fall out of range
                wait_idle();
                write_reg(REG_ROW_COUNT, CFG_W'($urandom_range(MAX_DIM, rows_in_use)));
                write_reg(REG_COL_COUNT, CFG_W'($urandom_range(MAX_DIM, cols_in_use)));
                repeat (4) queue_read(pick_layout(), pick_pos(15), pick_pos(15));
            end
        end
    endtask

    initial
    begin : run_test
        logic [CFG_W-1:0] rows_pick;
        logic [CFG_W-1:0] cols_pick;
        int phase_start;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset-size 1x1 matrix
        send_idle_pct = 30;
        recv_stall_pct = 30;
        queue_read(1'b1, 4'd15, 4'd15);
        queue_unused();
        queue_load(32'sh8000_0000);
        queue_load(32'sh7fff_ffff);
        queue_read(1'b0, 4'd0, 4'd0);
        queue_read(1'b1, 4'd0, 4'd0);
        queue_read(1'b0, 4'd1, 4'd0);
        queue_read(1'b1, 4'd0, 4'd15);
        queue_clear();

        // Directed: 3x2 with extreme values, both layouts and range misses
        wait_idle();
        write_reg(REG_ROW_COUNT, 5'd3);
        write_reg(REG_COL_COUNT, 5'd2);
        queue_load(32'sh7fff_ffff);
        queue_load(-32'sd1);
        queue_load(32'sd0);
        queue_load(32'sd1);
        queue_load(32'sh8000_0000);
        queue_load(-32'sd2);
        queue_read(1'b0, 4'd2, 4'd1);
        queue_read(1'b0, 4'd0, 4'd1);
        queue_read(1'b1, 4'd1, 4'd1);
        queue_read(1'b1, 4'd2, 4'd0);
        queue_read(1'b0, 4'd3, 4'd0);
        queue_read(1'b1, 4'd0, 4'd2);

        // Directed: enlarge after sorting, index past the loaded count
        wait_idle();
        write_reg(REG_ROW_COUNT, 5'd8);
        queue_read(1'b0, 4'd7, 4'd1);
        queue_read(1'b0, 4'd0, 4'd0);
        queue_clear();

        // Directed: shrink below the loaded count before sorting, zero row count
        wait_idle();
        write_reg(REG_ROW_COUNT, 5'd4);
        write_reg(REG_COL_COUNT, 5'd4);
        queue_load(32'sd100);
        queue_load(-32'sd100);
        queue_load(32'sd7);
        wait_idle();
        write_reg(REG_ROW_COUNT, 5'd0);
        write_reg(REG_COL_COUNT, 5'd2);
        queue_load(32'sd5);
        queue_read(1'b0, 4'd0, 4'd0);
        queue_clear();

        // Random rounds under each idle mix; the first round holds the output off
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 81;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 81;
                end
                default:
                begin
                    send_idle_pct = 30;
                    recv_stall_pct = 30;
                end
            endcase
            phase_start = stim_beats;
            if (phase == 0)
            begin
                random_round(5'd4, 5'd4, 1'b1);
            end
            while (stim_beats - phase_start < PHASE_BEATS)
            begin
                rows_pick = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(31))
                                                     : CFG_W'($urandom_range(4, 1));
                cols_pick = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(31))
                                                     : CFG_W'($urandom_range(4, 1));
                random_round(rows_pick, cols_pick, 1'b0);
            end
        end

        // Full-size matrix, with a column count above the limit
        random_round(5'd16, 5'd31, 1'b0);

        wait_idle();
        $display("Ran %0d command beats and %0d register writes; %0d results checked, %0d sorts.",
                 beats_taken, reg_writes, results_checked, sorts_done);
        $display("Idle mixes: none, sender, receiver, both; plus one long output hold-off.");
        if (fail_count == 0 && result_due.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
